// File: design/nbml_pkg.sv
// Shared types, widths and codes for the nine-bit mode link.
package nbml_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 9;
  localparam int POS_W       = 4;
  localparam int TX_CNT_W    = 12;
  localparam int RX_CNT_W    = 13;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [POS_W-1:0] DATA_BITS = 4'd9;
  localparam logic [POS_W-1:0] STOP_POS  = 4'd10;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_FRAME = 2'd1;
  localparam logic [OP_W-1:0] OP_LONE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SAMPLE = 2'd1;

  localparam logic [TX_CNT_W-1:0] BIT_TICKS_RST    = 12'd104;
  localparam logic [RX_CNT_W-1:0] START_SAMPLE_RST = 13'd156;

  typedef struct packed {
    logic level;
    logic accept;
    logic busy;
  } tx_res_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              mode;
    logic [BYTE_W-1:0] index;
  } rx_res_t;

  typedef struct packed {
    tx_res_t tx;
    rx_res_t rx;
  } res_t;

endpackage

// File: design/nbml_if.sv
// Valid/ready channel interfaces for tick input and per-tick result.
interface nbml_in_if;
  logic                        valid;
  logic                        ready;
  logic [nbml_pkg::OP_W-1:0]   op;
  logic [nbml_pkg::BYTE_W-1:0] tx_byte;
  logic                        tx_last;
  logic                        rx_level;

  modport source (output valid, op, tx_byte, tx_last, rx_level, input ready);
  modport sink   (input valid, op, tx_byte, tx_last, rx_level, output ready);
endinterface

interface nbml_out_if;
  logic                        valid;
  logic                        ready;
  logic                        tx_level;
  logic                        tx_accept;
  logic                        tx_busy;
  logic                        rx_valid;
  logic [nbml_pkg::BYTE_W-1:0] rx_data;
  logic                        rx_mode;
  logic [nbml_pkg::BYTE_W-1:0] rx_index;

  modport source (output valid, tx_level, tx_accept, tx_busy, rx_valid, rx_data, rx_mode,
                  rx_index, input ready);
  modport sink   (input valid, tx_level, tx_accept, tx_busy, rx_valid, rx_data, rx_mode,
                  rx_index, output ready);
endinterface

// File: design/nbml_tx.sv
// Transmit framer: bit timing, frame checksum and line level per tick.
module nbml_tx (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [nbml_pkg::OP_W-1:0]         op,
  input  logic [nbml_pkg::BYTE_W-1:0]       tx_byte,
  input  logic                              tx_last,
  input  logic [nbml_pkg::TX_CNT_W-1:0]     bit_ticks,
  output nbml_pkg::tx_res_t                 res
);

  logic [nbml_pkg::WORD_W-1:0]   word_r, word_nxt;
  logic [nbml_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [nbml_pkg::TX_CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [nbml_pkg::BYTE_W-1:0]   sum_r, sum_nxt;
  logic                          frame_r, frame_nxt;
  logic                          pending_r, pending_nxt;
  logic                          active_r, active_nxt;
  logic                          accept;
  logic [nbml_pkg::POS_W-1:0]    bit_idx;
  logic [nbml_pkg::WORD_W-1:0]   shifted;

  assign cnt_inc = cnt_r + 12'd1;

  always_comb begin
    word_nxt    = word_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    frame_nxt   = frame_r;
    pending_nxt = pending_r;
    active_nxt  = active_r;
    accept      = 1'b0;
    if (active_r) begin
      if (cnt_inc >= bit_ticks) begin
        cnt_nxt = '0;
        if (pos_r >= nbml_pkg::STOP_POS) begin
          active_nxt = 1'b0;
          pos_nxt    = '0;
        end else begin
          pos_nxt = pos_r + 4'd1;
        end
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
    if (!active_nxt && pending_r) begin
      pending_nxt = 1'b0;
      word_nxt    = {1'b0, sum_r};
      pos_nxt     = '0;
      cnt_nxt     = '0;
      active_nxt  = 1'b1;
    end
    if (!active_nxt && !pending_nxt) begin
      case (op)
        nbml_pkg::OP_FRAME: begin
          if (!frame_r) begin
            word_nxt  = {1'b1, tx_byte};
            sum_nxt   = tx_byte;
            frame_nxt = 1'b1;
          end else begin
            word_nxt = {1'b0, tx_byte};
            sum_nxt  = sum_r + tx_byte;
          end
          if (tx_last) begin
            pending_nxt = 1'b1;
            frame_nxt   = 1'b0;
          end
          pos_nxt    = '0;
          cnt_nxt    = '0;
          active_nxt = 1'b1;
          accept     = 1'b1;
        end
        nbml_pkg::OP_LONE: begin
          word_nxt   = {1'b1, tx_byte};
          pos_nxt    = '0;
          cnt_nxt    = '0;
          active_nxt = 1'b1;
          accept     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign bit_idx = pos_nxt - 4'd1;
  assign shifted = word_nxt >> bit_idx;

  always_comb begin
    res.accept = accept;
    res.busy   = active_nxt | pending_nxt;
    if (!active_nxt || pos_nxt >= nbml_pkg::STOP_POS) begin
      res.level = 1'b1;
    end else if (pos_nxt == '0) begin
      res.level = 1'b0;
    end else begin
      res.level = shifted[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r    <= '0;
      pos_r     <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
      frame_r   <= 1'b0;
      pending_r <= 1'b0;
      active_r  <= 1'b0;
    end else if (step) begin
      word_r    <= word_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      frame_r   <= frame_nxt;
      pending_r <= pending_nxt;
      active_r  <= active_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pending_out_of_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> !frame_r)
    else $error("checksum pending while frame still open");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> pos_r <= nbml_pkg::STOP_POS)
    else $error("transmit bit position out of range");
`endif

endmodule

// File: design/nbml_rx.sv
// Receive sampler: start detect, bit sampling and frame index per tick.
module nbml_rx (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          rx_level,
  input  logic [nbml_pkg::TX_CNT_W-1:0] bit_ticks,
  input  logic [nbml_pkg::RX_CNT_W-1:0] start_sample,
  output nbml_pkg::rx_res_t             res
);

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_FIRST,
    RX_BITS,
    RX_STOP
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [nbml_pkg::RX_CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc, bt_ext;
  logic [nbml_pkg::POS_W-1:0]    pos_r, pos_nxt, pos_inc;
  logic [nbml_pkg::WORD_W-1:0]   word_r, word_nxt;
  logic [nbml_pkg::BYTE_W-1:0]   position_r, position_nxt;

  assign cnt_inc = cnt_r + 13'd1;
  assign bt_ext  = {1'b0, bit_ticks};
  assign pos_inc = pos_r + 4'd1;

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    word_nxt     = word_r;
    position_nxt = position_r;
    res          = '0;
    case (phase_r)
      RX_IDLE: begin
        if (!rx_level) begin
          phase_nxt = RX_FIRST;
          cnt_nxt   = '0;
          word_nxt  = '0;
          pos_nxt   = '0;
        end
      end
      RX_FIRST: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= start_sample) begin
          word_nxt  = {{(nbml_pkg::WORD_W-1){1'b0}}, rx_level};
          pos_nxt   = 4'd1;
          cnt_nxt   = '0;
          phase_nxt = RX_BITS;
        end
      end
      RX_BITS: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= bt_ext) begin
          cnt_nxt = '0;
          if (pos_r < nbml_pkg::DATA_BITS) begin
            word_nxt = word_r | (nbml_pkg::WORD_W'(rx_level) << pos_r);
          end
          pos_nxt = pos_inc;
          if (pos_inc >= nbml_pkg::DATA_BITS) begin
            res.valid    = 1'b1;
            res.data     = word_nxt[nbml_pkg::BYTE_W-1:0];
            res.mode     = word_nxt[nbml_pkg::WORD_W-1];
            res.index    = position_r;
            position_nxt = word_nxt[nbml_pkg::WORD_W-1] ? '0 : position_r + 8'd1;
            phase_nxt    = RX_STOP;
          end
        end
      end
      default: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= bt_ext) begin
          cnt_nxt   = '0;
          phase_nxt = RX_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= RX_IDLE;
      cnt_r      <= '0;
      pos_r      <= '0;
      word_r     <= '0;
      position_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      pos_r      <= pos_nxt;
      word_r     <= word_nxt;
      position_r <= position_nxt;
    end
  end

`ifndef SYNTHESIS
  a_valid_from_bits: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (phase_r == RX_BITS && phase_nxt == RX_STOP))
    else $error("receive word completed outside data phase");
  a_bits_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == RX_BITS |-> (pos_r >= 4'd1 && pos_r < nbml_pkg::DATA_BITS))
    else $error("receive bit position out of range");
`endif

endmodule

// File: design/nbml_obuf.sv
// Output register with skid stage for per-tick results.
module nbml_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nbml_pkg::res_t push_data,
  output logic           push_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output nbml_pkg::res_t out_data
);

  logic           out_valid_r;
  logic           skid_valid_r;
  nbml_pkg::res_t out_data_r;
  nbml_pkg::res_t skid_data_r;
  logic           take;

  assign take       = out_valid_r & out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_data_r  <= push_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");
  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_ready && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("stalled transfer not captured in skid stage");
`endif

endmodule

// File: design/nine_bit_mode_link.sv
// Top level: nine-bit mode link with config registers and result buffering.
// Each accepted input transfer is one line tick and yields one result transfer.
// The result of each transfer is registered in the output register, or in the skid stage while the output stalls.
// Throughput: one tick per cycle while the skid stage is empty; in_ch.ready drops while it is full.
// Synchronous active-low reset idles both lines and loads bit_ticks 104 and
// start_sample_ticks 156; no clearing pass is needed.
module nine_bit_mode_link (
  input  logic                            clk,
  input  logic                            rst_n,
  nbml_in_if.sink                         in_ch,
  nbml_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [nbml_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nbml_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [nbml_pkg::TX_CNT_W-1:0] bit_ticks_r;
  logic [nbml_pkg::RX_CNT_W-1:0] start_sample_r;
  logic                          step;
  logic                          push_ready;
  nbml_pkg::tx_res_t             tx_res;
  nbml_pkg::rx_res_t             rx_res;
  nbml_pkg::res_t                res;
  nbml_pkg::res_t                out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r    <= nbml_pkg::BIT_TICKS_RST;
      start_sample_r <= nbml_pkg::START_SAMPLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nbml_pkg::CFG_BIT_TICKS:    bit_ticks_r    <= cfg_data[nbml_pkg::TX_CNT_W-1:0];
        nbml_pkg::CFG_START_SAMPLE: start_sample_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = push_ready;
  assign step        = in_ch.valid & push_ready;

  nbml_tx u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .op        (in_ch.op),
    .tx_byte   (in_ch.tx_byte),
    .tx_last   (in_ch.tx_last),
    .bit_ticks (bit_ticks_r),
    .res       (tx_res)
  );

  nbml_rx u_rx (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_level     (in_ch.rx_level),
    .bit_ticks    (bit_ticks_r),
    .start_sample (start_sample_r),
    .res          (rx_res)
  );

  assign res.tx = tx_res;
  assign res.rx = rx_res;

  nbml_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .push_data  (res),
    .push_ready (push_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data)
  );

  assign out_ch.tx_level  = out_data.tx.level;
  assign out_ch.tx_accept = out_data.tx.accept;
  assign out_ch.tx_busy   = out_data.tx.busy;
  assign out_ch.rx_valid  = out_data.rx.valid;
  assign out_ch.rx_data   = out_data.rx.data;
  assign out_ch.rx_mode   = out_data.rx.mode;
  assign out_ch.rx_index  = out_data.rx.index;

endmodule
